// ===== src/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types and character codes for the CESU-8 string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Width of the content length counter and of the capacity register.
  localparam int unsigned LenW = 16;

  localparam logic [LenW-1:0] CapReset = 16'd256;

  // Bytes that the scanner treats specially outside of an escape.
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChBslash = 8'h5c;

  // Phase of the string scanner.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_STRING = 2'd1,
    PH_ESCAPE = 2'd2,
    PH_HEX    = 2'd3
  } phase_e;

  // All results caused by one source byte, emitted in order data[0], data[1], ...
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] data;
    logic            byte_valid;
    logic            string_done;
    logic            truncated;
    logic            bad_hex;
  } group_t;

endpackage

// ===== src/jsu_byte_if.sv =====
// ----------------------------------------------------------------------------
// Source byte channel
// Valid/ready channel carrying one raw source byte per transaction.
// ----------------------------------------------------------------------------
interface jsu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== src/jsu_result_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one decoded result per transaction.
// ----------------------------------------------------------------------------
interface jsu_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;
  logic       truncated;
  logic       bad_hex;
  logic       last;

  modport source (output valid, output out_byte, output byte_valid, output string_done,
                  output truncated, output bad_hex, output last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input string_done,
                  input truncated, input bad_hex, input last, output ready);
endinterface

// ===== src/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// JSON string decoder
// Scanner state, escape and hex handling, CESU-8 encoding and capacity check.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [jsu_pkg::LenW-1:0]    cfg_wdata_i,
  input  logic                        accept_i,
  input  logic [7:0]                  in_byte_i,
  output jsu_pkg::group_t             group_o
);

  jsu_pkg::phase_e             phase_q, phase_d;
  logic [7:0]                  delim_q, delim_d;
  logic [1:0]                  seen_q, seen_d;
  logic [15:0]                 cp_q, cp_d;
  logic [jsu_pkg::LenW-1:0]    written_q, written_d;
  logic                        ovf_q, ovf_d;
  logic [jsu_pkg::LenW-1:0]    cap_q;

  logic                        blank;
  logic [3:0]                  hex_v;
  logic                        hex_bad;
  logic [15:0]                 cp_new;
  logic                        emit_req;
  logic                        emit_bad;
  logic [1:0]                  emit_n;
  logic [2:0][7:0]             emit_data;
  logic [jsu_pkg::LenW-1:0]    limit;
  logic [jsu_pkg::LenW:0]      sum;
  jsu_pkg::group_t             grp;

  assign blank  = (in_byte_i == jsu_pkg::ChSpace) || (in_byte_i == jsu_pkg::ChTab);
  assign cp_new = {cp_q[11:0], hex_v};
  assign limit  = (cap_q == '0) ? '0 : cap_q - 1'b1;

  always_comb begin
    hex_v   = 4'h0;
    hex_bad = 1'b0;
    if (in_byte_i inside {[8'h30:8'h39]}) begin
      hex_v = in_byte_i[3:0];
    end else if (in_byte_i inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      hex_v = in_byte_i[3:0] + 4'd9;
    end else begin
      hex_bad = 1'b1;
    end
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      jsu_pkg::PH_IDLE: begin
        if (!blank) phase_d = jsu_pkg::PH_STRING;
      end
      jsu_pkg::PH_STRING: begin
        if (in_byte_i == delim_q) phase_d = jsu_pkg::PH_IDLE;
        else if (in_byte_i == jsu_pkg::ChBslash) phase_d = jsu_pkg::PH_ESCAPE;
      end
      jsu_pkg::PH_ESCAPE: begin
        if (in_byte_i == "u") phase_d = jsu_pkg::PH_HEX;
        else phase_d = jsu_pkg::PH_STRING;
      end
      jsu_pkg::PH_HEX: begin
        if (seen_q == 2'd3) phase_d = jsu_pkg::PH_STRING;
      end
      default: phase_d = jsu_pkg::PH_IDLE;
    endcase
  end

  // Datapath and results.
  always_comb begin
    delim_d   = delim_q;
    seen_d    = seen_q;
    cp_d      = cp_q;
    written_d = written_q;
    ovf_d     = ovf_q;
    grp       = '0;
    emit_req  = 1'b0;
    emit_bad  = 1'b0;
    emit_n    = 2'd1;
    emit_data = '0;
    sum       = '0;
    case (phase_q)
      jsu_pkg::PH_IDLE: begin
        if (!blank) begin
          delim_d   = in_byte_i;
          written_d = '0;
          ovf_d     = 1'b0;
        end
      end
      jsu_pkg::PH_STRING: begin
        if (in_byte_i == delim_q) begin
          grp.cnt         = 2'd1;
          grp.string_done = 1'b1;
          grp.truncated   = ovf_q;
        end else if (in_byte_i != jsu_pkg::ChBslash) begin
          emit_req     = 1'b1;
          emit_data[0] = in_byte_i;
        end
      end
      jsu_pkg::PH_ESCAPE: begin
        emit_req = 1'b1;
        case (in_byte_i)
          8'h22:   emit_data[0] = 8'h22;
          8'h27:   emit_data[0] = 8'h27;
          8'h5c:   emit_data[0] = 8'h5c;
          "b":     emit_data[0] = 8'h08;
          "f":     emit_data[0] = 8'h0c;
          "n":     emit_data[0] = 8'h0a;
          "r":     emit_data[0] = 8'h0d;
          "t":     emit_data[0] = 8'h09;
          "u": begin
            emit_req = 1'b0;
            seen_d   = 2'd0;
            cp_d     = 16'h0000;
          end
          default: emit_req = 1'b0;
        endcase
      end
      jsu_pkg::PH_HEX: begin
        cp_d = cp_new;
        seen_d = seen_q + 2'd1;
        if (seen_q != 2'd3) begin
          if (hex_bad) begin
            grp.cnt     = 2'd1;
            grp.bad_hex = 1'b1;
          end
        end else begin
          emit_req = 1'b1;
          emit_bad = hex_bad;
          if (cp_new <= 16'h007f) begin
            emit_n       = 2'd1;
            emit_data[0] = cp_new[7:0];
          end else if (cp_new <= 16'h07ff) begin
            emit_n       = 2'd2;
            emit_data[0] = {3'b110, cp_new[10:6]};
            emit_data[1] = {2'b10, cp_new[5:0]};
          end else begin
            emit_n       = 2'd3;
            emit_data[0] = {4'b1110, cp_new[15:12]};
            emit_data[1] = {2'b10, cp_new[11:6]};
            emit_data[2] = {2'b10, cp_new[5:0]};
          end
        end
      end
      default: ;
    endcase

    // A multi-byte sequence is written whole or not at all.
    if (emit_req) begin
      sum = {1'b0, written_q} + {{(jsu_pkg::LenW-1){1'b0}}, emit_n};
      if (sum <= {1'b0, limit}) begin
        grp.cnt        = emit_n;
        grp.data       = emit_data;
        grp.byte_valid = 1'b1;
        grp.bad_hex    = emit_bad;
        written_d      = sum[jsu_pkg::LenW-1:0];
      end else begin
        grp.cnt       = 2'd1;
        grp.truncated = 1'b1;
        grp.bad_hex   = emit_bad;
        ovf_d         = 1'b1;
      end
    end
  end

  assign group_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= jsu_pkg::PH_IDLE;
      delim_q   <= '0;
      seen_q    <= '0;
      cp_q      <= '0;
      written_q <= '0;
      ovf_q     <= 1'b0;
      cap_q     <= jsu_pkg::CapReset;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (accept_i) begin
        phase_q   <= phase_d;
        delim_q   <= delim_d;
        seen_q    <= seen_d;
        cp_q      <= cp_d;
        written_q <= written_d;
        ovf_q     <= ovf_d;
      end
    end
  end

endmodule

// ===== src/jsu_serial.sv =====
// ----------------------------------------------------------------------------
// Result serializer
// Holds the results of one source byte and presents them one per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module jsu_serial (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  jsu_pkg::group_t    group_i,
  output logic               load_ok_o,
  jsu_result_if.source       out_o
);

  jsu_pkg::group_t grp_q;
  logic [1:0]      idx_q;
  logic            valid_q;
  logic            is_last;
  logic            take;

  assign is_last   = (idx_q == grp_q.cnt - 2'd1);
  assign take      = valid_q && out_o.ready;
  // The buffer can be refilled when it is empty or once its final result leaves in this cycle.
  assign load_ok_o = !valid_q || (take && is_last);

  assign out_o.valid       = valid_q;
  assign out_o.out_byte    = grp_q.data[idx_q];
  assign out_o.byte_valid  = grp_q.byte_valid;
  assign out_o.string_done = grp_q.string_done;
  assign out_o.truncated   = grp_q.truncated;
  assign out_o.bad_hex     = grp_q.bad_hex;
  assign out_o.last        = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (accept_i && (group_i.cnt != 2'd0)) begin
        valid_q <= 1'b1;
        idx_q   <= '0;
      end else if (take && is_last) begin
        valid_q <= 1'b0;
      end else if (take) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && (group_i.cnt != 2'd0)) grp_q <= group_i;
  end

endmodule

// ===== src/json_string_unescape_cesu8_unit.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper with CESU-8 output
// The first result of a source byte is offered in the cycle after its transaction.
// Throughput: one source byte per cycle while the sink is ready; a byte that decodes to two or three
// results holds the input while the result buffer drains.
// Reset: asynchronous, active low; scanner returns to idle and capacity to 256.
// ----------------------------------------------------------------------------
module json_string_unescape_cesu8_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [jsu_pkg::LenW-1:0]  cfg_wdata_i,
  jsu_byte_if.sink                  in_i,
  jsu_result_if.source              out_o
);

  // The decoder holds all scanner state and turns each source byte into a
  // group of zero to three results in one combinational pass. The serializer
  // registers that group and hands the results out one transaction at a time.
  jsu_pkg::group_t group;
  logic            load_ok;
  logic            accept;

  // A new source byte is taken whenever the result buffer is empty or its
  // final result is being taken in this same cycle, so the input waits only
  // until the last result of the held group is taken.
  assign in_i.ready = load_ok;
  assign accept     = in_i.valid && load_ok;

  jsu_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_byte_i   (in_i.in_byte),
    .group_o     (group)
  );

  jsu_serial u_serial (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .group_i   (group),
    .load_ok_o (load_ok),
    .out_o     (out_o)
  );

  // A byte is only accepted when no earlier result would be overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!out_o.valid || (out_o.ready && out_o.last)))
    else $error("source byte accepted over a pending result");

  // The closing result carries no content and ends its group.
  a_done_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.string_done) |-> (out_o.last && !out_o.byte_valid))
    else $error("string end result malformed");

  // Content never appears on the same result as truncation or the string end.
  a_trunc_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.byte_valid) |-> (!out_o.truncated && !out_o.string_done))
    else $error("content byte flagged as dropped");

  // A result held back by the sink keeps its content unchanged.
  a_hold_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.out_byte)))
    else $error("stalled result changed");

endmodule
